FILE: hdl/shum_pkg.sv
// ----------------------------------------------------------------------------
// shum_pkg: shared types and constants of the server health monitor
// Sample classes, sequencer states and field widths.
// ----------------------------------------------------------------------------
`default_nettype none
package shum_pkg;

  localparam int NUM_SERVERS_DEF  = 4;
  localparam int SAMPLE_DEPTH_DEF = 64;

  localparam int RTT_W   = 20;
  localparam int TIME_W  = 32;
  localparam int CNT_W   = 7;
  localparam int AVG_W   = 21;
  localparam int CLS_W   = 2;
  localparam int ENTRY_W = CLS_W + RTT_W + TIME_W;
  localparam int SUM_W   = 28;

  typedef enum logic [1:0] {
    CLS_SUCCESS  = 2'd0,
    CLS_ERROR    = 2'd1,
    CLS_TIMEOUT  = 2'd2,
    CLS_INTERNAL = 2'd3
  } cls_t;

  typedef enum logic [1:0] {
    CFG_SERVERS   = 2'd0,
    CFG_MIN       = 2'd1,
    CFG_THRESHOLD = 2'd2,
    CFG_VALIDITY  = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST_RD,
    ST_DIV_AVG,
    ST_RATE_MUL,
    ST_DIV_RATE,
    ST_JUDGE,
    ST_HOLD,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;

endpackage
`default_nettype wire

FILE: hdl/server_health_usability_monitor.sv
// ----------------------------------------------------------------------------
// server_health_usability_monitor: per-server sample rings and usability vote
// Records query outcomes into per-server rings and judges server health.
// ----------------------------------------------------------------------------
// Usage:
//  in_* channel (valid/ready): mode 0 records one sample into the ring of
//  in_server_index (no output); mode 1 evaluates servers 0..servers_in_use-1.
//  out_* channel (valid/ready): one transfer per evaluated server, in order,
//  out_last_result on the final one. Results are held in a small result
//  buffer; out_usable is resolved after all servers are judged (if no server
//  is usable, all are reported usable), so the results stream out at the end.
//  cfg_* port: write-only registers, written while idle.
// Timing:
//  A record is taken as one RAM write; the next item can follow at once.
//  An evaluate, per server, scans its filled slots over the single-port
//  sample RAM, reads the newest sample, divides for the mean if it has
//  successes, multiplies, divides for the rate if the server is judged
//  (then holds a step) and judges it. Then one result transfers per cycle
//  while the receiver is ready.
// Reset: ring fill counts and write positions clear; registers take their
//  defaults. The sample RAM is not cleared: only filled slots are read.
// Stall: a stalled receiver holds the sequencer in its emit step; no new
//  item is taken until every result has transferred.
// ----------------------------------------------------------------------------
`default_nettype none
module server_health_usability_monitor
  import shum_pkg::*;
#(
  parameter int NUM_SERVERS  = NUM_SERVERS_DEF,
  parameter int SAMPLE_DEPTH = SAMPLE_DEPTH_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_we,
  input  wire logic [1:0]                cfg_index,
  input  wire logic [31:0]               cfg_wdata,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic                      in_mode,
  input  wire logic [1:0]                in_server_index,
  input  wire logic [1:0]                in_outcome,
  input  wire logic [3:0]                in_rcode,
  input  wire logic [19:0]               in_rtt_ms,
  input  wire logic [31:0]               in_now_seconds,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [1:0]                     out_server_id,
  output logic                           out_usable,
  output logic [6:0]                     out_success_count,
  output logic [6:0]                     out_error_count,
  output logic [6:0]                     out_timeout_count,
  output logic [6:0]                     out_internal_error_count,
  output logic signed [20:0]             out_average_rtt,
  output logic [31:0]                    out_newest_sample_time,
  output logic                           out_last_result
);
  localparam int SW = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;
  localparam int PW = $clog2(SAMPLE_DEPTH);
  localparam int FW = $clog2(SAMPLE_DEPTH + 1);
  localparam int AW = $clog2(NUM_SERVERS * SAMPLE_DEPTH);
  localparam int NW = $clog2(NUM_SERVERS + 1);

  // configuration
  logic [2:0]  cfg_servers_r;
  logic [6:0]  cfg_min_r, cfg_thr_r;
  logic [31:0] cfg_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_servers_r <= 3'd4;
      cfg_min_r     <= 7'd8;
      cfg_thr_r     <= 7'd25;
      cfg_valid_r   <= 32'd1800;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SERVERS:   cfg_servers_r <= cfg_wdata[2:0];
        CFG_MIN:       cfg_min_r     <= cfg_wdata[6:0];
        CFG_THRESHOLD: cfg_thr_r     <= cfg_wdata[6:0];
        CFG_VALIDITY:  cfg_valid_r   <= cfg_wdata;
      endcase
    end
  end

  // per-server ring pointers (flops, cleared by reset)
  logic [FW-1:0] fill_r [NUM_SERVERS];
  logic [PW-1:0] wpos_r [NUM_SERVERS];

  // sample RAM
  logic               ram_we;
  logic [AW-1:0]      ram_addr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

  shum_ram #(.WIDTH(ENTRY_W), .DEPTH(NUM_SERVERS * SAMPLE_DEPTH)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  // divider
  logic             div_start;
  logic [SUM_W-1:0] div_a, div_b, div_q;
  div_ctl_t         div_ctl;

  shum_div #(.W(SUM_W)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_a),
    .divisor(div_b), .quotient(div_q), .ctl(div_ctl)
  );

  // sequencer
  state_t state_r, state_nxt;
  logic [SW-1:0]    srv_r, srv_nxt;
  logic [NW-1:0]    n_r, n_nxt;
  logic [FW-1:0]    idx_r, idx_nxt;      // slots issued
  logic             rd_v_r, rd_v_nxt;    // RAM read data valid
  logic [CNT_W-1:0] c_s_r, c_e_r, c_t_r, c_i_r;
  logic [CNT_W-1:0] c_s_nxt, c_e_nxt, c_t_nxt, c_i_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [SUM_W-1:0] prod_r, prod_nxt;
  logic [31:0]      now_r, now_nxt;
  logic [31:0]      last_r, last_nxt;
  logic [AVG_W-1:0] avg_r, avg_nxt;
  logic [NUM_SERVERS-1:0] ok_r, ok_nxt;
  logic [NUM_SERVERS-1:0] clr_r, clr_nxt;
  logic [SW-1:0]    emit_r, emit_nxt;

  // result buffer, one entry per server at a fixed place
  logic [CNT_W-1:0] rb_s_r [NUM_SERVERS];
  logic [CNT_W-1:0] rb_e_r [NUM_SERVERS];
  logic [CNT_W-1:0] rb_t_r [NUM_SERVERS];
  logic [CNT_W-1:0] rb_i_r [NUM_SERVERS];
  logic [AVG_W-1:0] rb_a_r [NUM_SERVERS];
  logic [31:0]      rb_l_r [NUM_SERVERS];
  logic             rb_we;

  logic [CLS_W-1:0] rec_cls;
  logic [FW-1:0]    cur_fill;
  logic [PW-1:0]    cur_wp, last_slot;
  logic [CNT_W:0]   total;
  logic signed [33:0] age;
  logic             judged;
  logic [2:0]       n_lim;

  always_comb begin
    if (in_outcome == 2'd1)      rec_cls = CLS_TIMEOUT;
    else if (in_outcome == 2'd2) rec_cls = CLS_INTERNAL;
    else if (in_outcome == 2'd0 &&
             (in_rcode == 4'd0 || in_rcode == 4'd3 || in_rcode == 4'd9))
      rec_cls = CLS_SUCCESS;
    else rec_cls = CLS_ERROR;
  end

  assign cur_fill  = fill_r[srv_r];
  assign cur_wp    = wpos_r[srv_r];
  assign last_slot = (cur_wp != '0) ? cur_wp - 1'b1 : PW'(cur_fill - 1'b1);
  assign total     = {1'b0, c_s_r} + {1'b0, c_e_r} + {1'b0, c_t_r};
  assign age       = $signed({2'b00, now_r}) - $signed({2'b00, last_r});
  assign judged    = (total >= {1'b0, cfg_min_r}) && (c_e_r != '0 || c_t_r != '0);
  assign n_lim     = (32'(cfg_servers_r) > NUM_SERVERS) ? 3'(NUM_SERVERS) : cfg_servers_r;

  always_comb begin
    state_nxt = state_r;
    srv_nxt = srv_r; n_nxt = n_r; idx_nxt = idx_r; rd_v_nxt = 1'b0;
    c_s_nxt = c_s_r; c_e_nxt = c_e_r; c_t_nxt = c_t_r; c_i_nxt = c_i_r;
    sum_nxt = sum_r; prod_nxt = prod_r; now_nxt = now_r; last_nxt = last_r;
    avg_nxt = avg_r; ok_nxt = ok_r; clr_nxt = clr_r; emit_nxt = emit_r;
    in_ready = 1'b0; ram_we = 1'b0; ram_addr = '0; ram_wdata = '0;
    div_start = 1'b0; div_a = sum_r; div_b = SUM_W'(c_s_r); rb_we = 1'b0;
    out_valid = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        ram_addr = AW'({in_server_index, wpos_r[SW'(in_server_index)]});
        ram_wdata = {rec_cls, in_rtt_ms, in_now_seconds};
        if (in_valid) begin
          if (!in_mode) begin
            ram_we = (32'(in_server_index) < NUM_SERVERS);
            ram_addr = AW'((32'(in_server_index) * SAMPLE_DEPTH) +
                           32'(wpos_r[SW'(in_server_index)]));
          end else if (n_lim != '0) begin
            n_nxt = NW'(n_lim); srv_nxt = '0; idx_nxt = '0; now_nxt = in_now_seconds;
            c_s_nxt = '0; c_e_nxt = '0; c_t_nxt = '0; c_i_nxt = '0; sum_nxt = '0;
            ok_nxt = '0; clr_nxt = '0;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        ram_addr = AW'(32'(srv_r) * SAMPLE_DEPTH + 32'(PW'(idx_r)));
        if (rd_v_r) begin
          unique case (cls_t'(ram_rdata[ENTRY_W-1 -: CLS_W]))
            CLS_SUCCESS: begin
              c_s_nxt = c_s_r + 1'b1;
              sum_nxt = sum_r + SUM_W'(ram_rdata[TIME_W +: RTT_W]);
            end
            CLS_ERROR:    c_e_nxt = c_e_r + 1'b1;
            CLS_TIMEOUT:  c_t_nxt = c_t_r + 1'b1;
            CLS_INTERNAL: c_i_nxt = c_i_r + 1'b1;
          endcase
        end
        if (idx_r < cur_fill) begin
          idx_nxt = idx_r + 1'b1;
          rd_v_nxt = 1'b1;
        end else begin
          ram_addr = AW'(32'(srv_r) * SAMPLE_DEPTH + 32'(last_slot));
          state_nxt = ST_LAST_RD;
        end
      end
      ST_LAST_RD: begin
        // read data is the newest-sample slot issued on scan exit
        last_nxt = (cur_fill != '0) ? ram_rdata[TIME_W-1:0] : '0;
        if (c_s_r != '0) begin
          div_start = 1'b1;
          state_nxt = ST_DIV_AVG;
        end else begin
          avg_nxt = '1;
          state_nxt = ST_RATE_MUL;
        end
      end
      ST_DIV_AVG: begin
        if (div_ctl.done) begin
          avg_nxt = AVG_W'(div_q);
          state_nxt = ST_RATE_MUL;
        end
      end
      ST_RATE_MUL: begin
        prod_nxt = SUM_W'(c_s_r) * SUM_W'(100);
        state_nxt = judged ? ST_DIV_RATE : ST_JUDGE;
      end
      ST_DIV_RATE: begin
        div_a = prod_r; div_b = SUM_W'(total);
        if (!div_ctl.busy && !div_ctl.done) begin
          div_start = 1'b1;
        end else if (div_ctl.done) begin
          prod_nxt = div_q;
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        state_nxt = ST_JUDGE;
      end
      ST_JUDGE: begin
        rb_we = 1'b1;
        ok_nxt[srv_r] = 1'b1;
        if (judged && prod_r < SUM_W'(cfg_thr_r)) begin
          if (age > $signed({2'b00, cfg_valid_r})) clr_nxt[srv_r] = 1'b1;
          else ok_nxt[srv_r] = 1'b0;
        end
        c_s_nxt = '0; c_e_nxt = '0; c_t_nxt = '0; c_i_nxt = '0; sum_nxt = '0;
        idx_nxt = '0;
        if (NW'(srv_r) + 1'b1 == n_r) begin
          emit_nxt = '0;
          state_nxt = ST_EMIT;
        end else begin
          srv_nxt = srv_r + 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          emit_nxt = emit_r + 1'b1;
          if (NW'(emit_r) + 1'b1 == n_r) state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // The final scan read returns in ST_SCAN's exit cycle; it is counted there.
  // ST_LAST_RD then sees the newest-sample read issued on exit.

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      rd_v_r  <= 1'b0;
      for (int s = 0; s < NUM_SERVERS; s++) begin
        fill_r[s] <= '0;
        wpos_r[s] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      rd_v_r  <= rd_v_nxt;
      if (ram_we) begin
        wpos_r[SW'(in_server_index)] <=
          (wpos_r[SW'(in_server_index)] == PW'(SAMPLE_DEPTH - 1)) ? '0
                                     : wpos_r[SW'(in_server_index)] + 1'b1;
        if (fill_r[SW'(in_server_index)] != FW'(SAMPLE_DEPTH))
          fill_r[SW'(in_server_index)] <= fill_r[SW'(in_server_index)] + 1'b1;
      end
      if (state_r == ST_EMIT && state_nxt == ST_IDLE) begin
        for (int s = 0; s < NUM_SERVERS; s++) begin
          if (clr_r[s]) begin
            fill_r[s] <= '0;
            wpos_r[s] <= '0;
          end
        end
      end
    end
    srv_r <= srv_nxt; n_r <= n_nxt; idx_r <= idx_nxt;
    c_s_r <= c_s_nxt; c_e_r <= c_e_nxt; c_t_r <= c_t_nxt; c_i_r <= c_i_nxt;
    sum_r <= sum_nxt; prod_r <= prod_nxt; now_r <= now_nxt; last_r <= last_nxt;
    avg_r <= avg_nxt; ok_r <= ok_nxt; clr_r <= clr_nxt; emit_r <= emit_nxt;
    if (rb_we) begin
      rb_s_r[srv_r] <= c_s_r; rb_e_r[srv_r] <= c_e_r;
      rb_t_r[srv_r] <= c_t_r; rb_i_r[srv_r] <= c_i_r;
      rb_a_r[srv_r] <= avg_r; rb_l_r[srv_r] <= last_r;
    end
  end

  // output view of the result buffer
  assign out_server_id            = 2'(emit_r);
  assign out_usable               = (ok_r == '0) || ok_r[emit_r];
  assign out_success_count        = rb_s_r[emit_r];
  assign out_error_count          = rb_e_r[emit_r];
  assign out_timeout_count        = rb_t_r[emit_r];
  assign out_internal_error_count = rb_i_r[emit_r];
  assign out_average_rtt          = $signed(rb_a_r[emit_r]);
  assign out_newest_sample_time   = rb_l_r[emit_r];
  assign out_last_result          = (NW'(emit_r) + 1'b1 == n_r);

`ifndef SYNTH
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid) else $error("accepting while results pending");
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r[0] <= FW'(SAMPLE_DEPTH)) else $error("fill count overflow");
  a_eval_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_mode && n_lim != '0 |=> state_r == ST_SCAN)
    else $error("evaluate did not start");
  a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> state_r == ST_IDLE) else $error("ring write during evaluate");
`endif
endmodule
`default_nettype wire

FILE: hdl/shum_ram.sv
// ----------------------------------------------------------------------------
// shum_ram: generic single-port synchronous RAM
// One write or one read per cycle, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none
module shum_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

FILE: hdl/shum_div.sv
// ----------------------------------------------------------------------------
// shum_div: radix-2 restoring divider
// One quotient bit per cycle; divisor must be nonzero.
// ----------------------------------------------------------------------------
`default_nettype none
module shum_div
  import shum_pkg::*;
#(
  parameter int W = 28
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic [W-1:0] dividend,
  input  wire logic [W-1:0] divisor,
  output logic      [W-1:0] quotient,
  output div_ctl_t          ctl
);
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  q_r, q_nxt, d_r, d_nxt;
  logic [W:0]    rem_r, rem_nxt, trial;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt, done_r, done_nxt;

  always_comb begin
    q_nxt    = q_r;
    d_nxt    = d_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[W-1:0], q_r[W-1]} - {1'b0, d_r};
    if (start) begin
      q_nxt    = dividend;
      d_nxt    = divisor;
      rem_nxt  = '0;
      cnt_nxt  = CW'(W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[W]) begin
        rem_nxt = trial;
        q_nxt   = {q_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[W-1:0], q_r[W-1]};
        q_nxt   = {q_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    d_r   <= d_nxt;
    rem_r <= rem_nxt;
  end

  assign quotient  = q_r;
  assign ctl.start = start;
  assign ctl.busy  = busy_r;
  assign ctl.done  = done_r;

`ifndef SYNTH
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("divider done without busy");
  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !start |=> busy_r || done_r) else $error("divider dropped busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("divider done held");
`endif
endmodule
`default_nettype wire

FILE: test/server_health_usability_monitor_tb.sv
// ----------------------------------------------------------------------------
// server_health_usability_monitor_tb: self-checking bench for the monitor
// Records random query outcomes into the per-server rings, runs evaluations
// under several register settings and checks every per-server result against
// a behavioral predictor, with random idling on both channels.
// ----------------------------------------------------------------------------
`default_nettype none
module server_health_usability_monitor_tb;
  import shum_pkg::*;

  localparam int NSRV  = 4;
  localparam int DEPTH = 64;
  localparam int WATCHDOG_LIMIT = 20000;

  // One input item as queued for the driver.
  typedef struct packed {
    logic        mode;
    logic [1:0]  server_index;
    logic [1:0]  outcome;
    logic [3:0]  rcode;
    logic [19:0] rtt_ms;
    logic [31:0] now_seconds;
  } query_t;

  // One per-server health report.
  typedef struct packed {
    logic [1:0]         server_id;
    logic               usable;
    logic [6:0]         success_count;
    logic [6:0]         error_count;
    logic [6:0]         timeout_count;
    logic [6:0]         internal_error_count;
    logic signed [20:0] average_rtt;
    logic [31:0]        newest_sample_time;
    logic               last_result;
  } report_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [31:0] cfg_wdata;
  logic in_valid;
  logic in_ready;
  logic in_mode;
  logic [1:0] in_server_index;
  logic [1:0] in_outcome;
  logic [3:0] in_rcode;
  logic [19:0] in_rtt_ms;
  logic [31:0] in_now_seconds;
  logic out_valid;
  logic out_ready;
  logic [1:0] out_server_id;
  logic out_usable;
  logic [6:0] out_success_count;
  logic [6:0] out_error_count;
  logic [6:0] out_timeout_count;
  logic [6:0] out_internal_error_count;
  logic signed [20:0] out_average_rtt;
  logic [31:0] out_newest_sample_time;
  logic out_last_result;

  server_health_usability_monitor u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_mode(in_mode), .in_server_index(in_server_index),
    .in_outcome(in_outcome), .in_rcode(in_rcode),
    .in_rtt_ms(in_rtt_ms), .in_now_seconds(in_now_seconds),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_server_id(out_server_id), .out_usable(out_usable),
    .out_success_count(out_success_count), .out_error_count(out_error_count),
    .out_timeout_count(out_timeout_count),
    .out_internal_error_count(out_internal_error_count),
    .out_average_rtt(out_average_rtt),
    .out_newest_sample_time(out_newest_sample_time),
    .out_last_result(out_last_result)
  );

  // Predictor state: shadow registers and sample rings.
  logic [2:0]  servers_cfg;
  logic [6:0]  min_samples_cfg;
  logic [6:0]  threshold_cfg;
  logic [31:0] validity_cfg;
  cls_t        ring_cls  [NSRV][DEPTH];
  logic [19:0] ring_rtt  [NSRV][DEPTH];
  logic [31:0] ring_time [NSRV][DEPTH];
  int unsigned ring_fill [NSRV];
  int unsigned ring_wpos [NSRV];

  query_t  pending_q[$];
  report_t health_q[$];
  int      fail_count;
  int      idle_pct;      // percent of cycles each side idles
  int      stall_cycles;

  // Store one sample in the shadow ring.
  function automatic void record_sample(query_t q);
    cls_t c;
    int   s;
    s = q.server_index;
    if (q.outcome == 2'd1)      c = CLS_TIMEOUT;
    else if (q.outcome == 2'd2) c = CLS_INTERNAL;
    else if (q.outcome == 2'd0 && (q.rcode == 4'd0 || q.rcode == 4'd3 || q.rcode == 4'd9))
      c = CLS_SUCCESS;
    else c = CLS_ERROR;         // rcode errors and outcome code three
    ring_cls[s][ring_wpos[s]]  = c;
    ring_rtt[s][ring_wpos[s]]  = q.rtt_ms;
    ring_time[s][ring_wpos[s]] = q.now_seconds;
    ring_wpos[s] = (ring_wpos[s] + 1) % DEPTH;
    if (ring_fill[s] < DEPTH) ring_fill[s]++;
  endfunction

  // Judge every server in use and queue the expected reports.
  function automatic void judge_servers(logic [31:0] now);
    report_t r [NSRV];
    int n, found;
    int unsigned cnt [4];
    longint unsigned rtt_sum, total, rate;
    longint age;
    logic [31:0] newest;
    bit ok;
    n = (servers_cfg > NSRV) ? NSRV : servers_cfg;
    found = 0;
    for (int s = 0; s < n; s++) begin
      cnt = '{0, 0, 0, 0};
      rtt_sum = 0;
      newest = '0;
      ok = 1'b1;
      for (int i = 0; i < ring_fill[s]; i++) begin
        cnt[ring_cls[s][i]]++;
        if (ring_cls[s][i] == CLS_SUCCESS) rtt_sum += ring_rtt[s][i];
      end
      if (ring_fill[s] > 0)
        newest = (ring_wpos[s] > 0) ? ring_time[s][ring_wpos[s] - 1]
                                    : ring_time[s][ring_fill[s] - 1];
      r[s].server_id            = 2'(s);
      r[s].success_count        = 7'(cnt[CLS_SUCCESS]);
      r[s].error_count          = 7'(cnt[CLS_ERROR]);
      r[s].timeout_count        = 7'(cnt[CLS_TIMEOUT]);
      r[s].internal_error_count = 7'(cnt[CLS_INTERNAL]);
      r[s].average_rtt = (cnt[CLS_SUCCESS] != 0) ? 21'(rtt_sum / cnt[CLS_SUCCESS]) : -21'sd1;
      r[s].newest_sample_time   = newest;
      r[s].last_result          = (s + 1 == n);
      total = cnt[CLS_SUCCESS] + cnt[CLS_ERROR] + cnt[CLS_TIMEOUT];
      if (total >= min_samples_cfg && (cnt[CLS_ERROR] > 0 || cnt[CLS_TIMEOUT] > 0)) begin
        rate = cnt[CLS_SUCCESS] * 100 / total;
        if (rate < threshold_cfg) begin
          age = longint'(now) - longint'(newest);
          if (age > longint'(validity_cfg)) begin
            // stale: forget the samples, server stays usable
            ring_fill[s] = 0;
            ring_wpos[s] = 0;
          end else ok = 1'b0;
        end
      end
      r[s].usable = ok;
      if (ok) found++;
    end
    for (int s = 0; s < n; s++) begin
      if (found == 0) r[s].usable = 1'b1;
      health_q.push_back(r[s]);
    end
  endfunction

  // Clock.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Driver: presents the oldest pending query, idling at random between
  // transfers. The predictor runs on each accepted transfer.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        if (pending_q[0].mode) judge_servers(pending_q[0].now_seconds);
        else record_sample(pending_q[0]);
        void'(pending_q.pop_front());
      end
      if ((!in_valid || in_ready) ) begin
        if (pending_q.size() > (in_valid && in_ready ? 0 : 0) && pending_q.size() != 0
            && $urandom_range(99) >= idle_pct) begin
          in_valid        <= 1'b1;
          in_mode         <= pending_q[0].mode;
          in_server_index <= pending_q[0].server_index;
          in_outcome      <= pending_q[0].outcome;
          in_rcode        <= pending_q[0].rcode;
          in_rtt_ms       <= pending_q[0].rtt_ms;
          in_now_seconds  <= pending_q[0].now_seconds;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares each result transfer with the oldest expected report.
  always @(posedge clk) begin
    report_t exp_r;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (health_q.size() == 0) begin
          $error("unexpected result transfer for server %0d", out_server_id);
          fail_count++;
        end else begin
          exp_r = health_q.pop_front();
          if (out_server_id !== exp_r.server_id) begin
            $error("server_id exp %0d got %0d", exp_r.server_id, out_server_id); fail_count++;
          end
          if (out_usable !== exp_r.usable) begin
            $error("usable exp %0d got %0d", exp_r.usable, out_usable); fail_count++;
          end
          if (out_success_count !== exp_r.success_count) begin
            $error("success_count exp %0d got %0d", exp_r.success_count, out_success_count);
            fail_count++;
          end
          if (out_error_count !== exp_r.error_count) begin
            $error("error_count exp %0d got %0d", exp_r.error_count, out_error_count);
            fail_count++;
          end
          if (out_timeout_count !== exp_r.timeout_count) begin
            $error("timeout_count exp %0d got %0d", exp_r.timeout_count, out_timeout_count);
            fail_count++;
          end
          if (out_internal_error_count !== exp_r.internal_error_count) begin
            $error("internal_error_count exp %0d got %0d", exp_r.internal_error_count,
                   out_internal_error_count);
            fail_count++;
          end
          if (out_average_rtt !== exp_r.average_rtt) begin
            $error("average_rtt exp %0d got %0d", exp_r.average_rtt, out_average_rtt);
            fail_count++;
          end
          if (out_newest_sample_time !== exp_r.newest_sample_time) begin
            $error("newest_sample_time exp %0d got %0d", exp_r.newest_sample_time,
                   out_newest_sample_time);
            fail_count++;
          end
          if (out_last_result !== exp_r.last_result) begin
            $error("last_result exp %0d got %0d", exp_r.last_result, out_last_result);
            fail_count++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // Watchdog: counts cycles without any transfer.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("server_health_usability_monitor_tb: FAIL");
      $finish;
    end
  end

  function automatic query_t make_record(int srv, int oc, int rc, int rtt, logic [31:0] at);
    query_t q;
    q = '{mode: 1'b0, server_index: 2'(srv), outcome: 2'(oc), rcode: 4'(rc),
          rtt_ms: 20'(rtt), now_seconds: at};
    return q;
  endfunction

  function automatic query_t make_eval(logic [31:0] now);
    query_t q;
    q = '0;
    q.mode = 1'b1;
    q.server_index = 2'($urandom);
    q.outcome = 2'($urandom);
    q.rcode = 4'($urandom);
    q.rtt_ms = 20'($urandom);
    q.now_seconds = now;
    return q;
  endfunction

  // Wait until the block has drained, then settle past its last step.
  task automatic drain();
    wait (pending_q.size() == 0 && !in_valid);
    wait (health_q.size() == 0);
    repeat (50) @(posedge clk);
  endtask

  // Register write while the block is idle.
  task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_SERVERS:   servers_cfg     = val[2:0];
      CFG_MIN:       min_samples_cfg = val[6:0];
      CFG_THRESHOLD: threshold_cfg   = val[6:0];
      default:       validity_cfg    = val;
    endcase
  endtask

  // A random sample; mostly well-formed outcomes, a few outcome code three.
  function automatic query_t rand_record(logic [31:0] base_time);
    int oc;
    oc = ($urandom_range(99) < 5) ? 3 : $urandom_range(2);
    return make_record($urandom_range(3), oc, $urandom_range(15),
                       ($urandom_range(9) == 0) ? $urandom : $urandom_range(5000),
                       base_time + $urandom_range(100));
  endfunction

  initial begin
    logic [31:0] tnow;
    int phase_items;
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_index = CFG_SERVERS; cfg_wdata = '0;
    in_valid = 1'b0; in_mode = 1'b0; in_server_index = '0; in_outcome = '0;
    in_rcode = '0; in_rtt_ms = '0; in_now_seconds = '0;
    out_ready = 1'b0;
    fail_count = 0; stall_cycles = 0;
    idle_pct = 14;
    servers_cfg = 3'd4; min_samples_cfg = 7'd8; threshold_cfg = 7'd25;
    validity_cfg = 32'd1800;
    for (int s = 0; s < NSRV; s++) begin
      ring_fill[s] = 0;
      ring_wpos[s] = 0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty rings, field extremes, every outcome, outcome three.
    pending_q.push_back(make_eval(32'd0));
    pending_q.push_back(make_record(0, 0, 0, 0, 32'd0));
    pending_q.push_back(make_record(0, 0, 3, 20'hFFFFF, 32'hFFFF_FFFF));
    pending_q.push_back(make_record(0, 0, 9, 20'hFFFFF, 32'd100));
    pending_q.push_back(make_record(1, 0, 15, 20'hAAAAA, 32'h5555_5555));
    pending_q.push_back(make_record(1, 1, 0, 20'h55555, 32'hAAAA_AAAA));
    pending_q.push_back(make_record(2, 2, 0, 7, 32'd200));
    pending_q.push_back(make_record(3, 3, 0, 9, 32'd300));
    pending_q.push_back(make_record(3, 0, 1, 9, 32'd301));
    pending_q.push_back(make_eval(32'hFFFF_FFFF));
    pending_q.push_back(make_eval(32'd0));
    drain();

    // All servers bad and fresh: every one reported usable anyway.
    write_reg(CFG_MIN, 7'd0);
    write_reg(CFG_THRESHOLD, 7'd100);
    write_reg(CFG_VALIDITY, 32'hFFFF_FFFF);
    for (int s = 0; s < NSRV; s++) pending_q.push_back(make_record(s, 1, 0, 1, 32'd50));
    pending_q.push_back(make_eval(32'd60));
    drain();

    // Servers in use zero and above the server count.
    write_reg(CFG_SERVERS, 3'd0);
    pending_q.push_back(make_eval(32'd70));
    pending_q.push_back(make_record(0, 0, 0, 3, 32'd80));
    drain();
    write_reg(CFG_SERVERS, 3'd7);
    pending_q.push_back(make_eval(32'd90));
    drain();

    // Random phases over several register settings; records go to all four servers at random.
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CFG_SERVERS, (ph == 1) ? 3'd1 : $urandom_range(1, 4));
      write_reg(CFG_MIN, (ph == 2) ? 7'd64 : (ph == 3) ? 7'd0 : $urandom_range(0, 20));
      write_reg(CFG_THRESHOLD, (ph == 4) ? 7'd0 : (ph == 5) ? 7'd100
                                         : $urandom_range(10, 90));
      write_reg(CFG_VALIDITY, (ph == 6) ? 32'd0 : (ph == 7) ? 32'hFFFF_FFFF
                                        : $urandom_range(50, 2000));
      idle_pct = (ph == 3) ? 0 : 14;     // one stretch with no idling
      tnow = $urandom;
      phase_items = (ph == 2) ? 150 : 40;
      for (int k = 0; k < phase_items; k++) begin
        if ($urandom_range(99) < 12) begin
          tnow = ($urandom_range(3) == 0) ? tnow - $urandom_range(100)
                                          : tnow + $urandom_range(3000);
          pending_q.push_back(make_eval(tnow));
        end else begin
          pending_q.push_back(rand_record(tnow));
        end
      end
      pending_q.push_back(make_eval(tnow + $urandom_range(4000)));
      if (ph == 4) begin
        // sender holds off until every result is back
        wait (pending_q.size() == 0 && !in_valid);
        wait (health_q.size() == 0);
        pending_q.push_back(make_eval(tnow));
      end
      drain();
    end

    if (fail_count == 0 && health_q.size() == 0)
      $display("server_health_usability_monitor_tb: PASS");
    else
      $display("server_health_usability_monitor_tb: FAIL");
    $finish;
  end

endmodule
`default_nettype wire
